### rtl/core/assert_macros.svh
// Assertion helpers, sampled on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define WBPS_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wbps assertion failed");

// Next-cycle implication.
`define WBPS_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wbps assertion failed");

`endif

### rtl/core/wbps_pkg.sv
package wbps_pkg;

    localparam int MAX_PATTERN  = 64;
    localparam int PIDX_W       = $clog2(MAX_PATTERN);
    localparam int CNT_W        = $clog2(MAX_PATTERN + 1);
    localparam int ADDR_W       = 48;
    localparam int CFG_LEN_W    = 7;
    localparam int CFG_DATA_W   = 48;
    localparam int CFG_IDX_W    = 1;
    localparam int REQ_W        = 2;
    localparam int ENTRY_IDX_W  = 6;
    localparam int BYTE_W       = 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SCAN    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START  = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]       kind;
        logic [ENTRY_IDX_W-1:0] index;
        logic [BYTE_W-1:0]      value;
        logic                   wild;
        logic                   last;
    } cmd_t;

    function automatic logic [CNT_W-1:0] eff_len(input logic [CFG_LEN_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0)
        begin
            r = CNT_W'(1);
        end
        else if (int'(v) > MAX_PATTERN)
        begin
            r = CNT_W'(MAX_PATTERN);
        end
        else
        begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

endpackage

### rtl/core/wbps_front.sv
module wbps_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [wbps_pkg::REQ_W-1:0]       req_type,
    input  logic [wbps_pkg::ENTRY_IDX_W-1:0] entry_index,
    input  logic [wbps_pkg::BYTE_W-1:0]      entry_value,
    input  logic                             entry_wild,
    input  logic [wbps_pkg::BYTE_W-1:0]      data_byte,
    input  logic                             last_byte,
    output logic                             push_valid,
    input  logic                             push_ready,
    output wbps_pkg::cmd_t                   push_cmd
);
    import wbps_pkg::*;

    logic f_valid_reg;
    logic f_valid_next;
    cmd_t f_cmd_reg;
    cmd_t f_cmd_next;
    logic accept;
    logic known;

    assign in_ready   = !f_valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = f_valid_reg;
    assign push_cmd   = f_cmd_reg;

    always_comb
    begin
        known        = req_type inside {REQ_LOAD, REQ_SCAN, REQ_RESTART};
        f_valid_next = f_valid_reg && !push_ready;
        f_cmd_next   = f_cmd_reg;
        if (accept)
        begin
            // drop unknown request types here
            f_valid_next     = known;
            f_cmd_next.kind  = req_type;
            f_cmd_next.index = entry_index;
            f_cmd_next.value = (req_type == REQ_LOAD) ? entry_value : data_byte;
            f_cmd_next.wild  = entry_wild;
            f_cmd_next.last  = last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_cmd_reg <= f_cmd_next;
    end

endmodule

### rtl/core/wbps_queue.sv
module wbps_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  wbps_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop,
    output wbps_pkg::cmd_t pop_cmd
);
    import wbps_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/core/wbps_back.sv
module wbps_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            q_valid,
    input  wbps_pkg::cmd_t                  q_cmd,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            found,
    output logic [wbps_pkg::ADDR_W-1:0]     match_address
);
    import wbps_pkg::*;

    logic [BYTE_W-1:0]      win_reg  [MAX_PATTERN];
    logic [BYTE_W-1:0]      win_next [MAX_PATTERN];
    logic [BYTE_W-1:0]      aln_reg  [MAX_PATTERN];
    logic [BYTE_W-1:0]      aln_next [MAX_PATTERN];
    logic [BYTE_W-1:0]      aln_shift [MAX_PATTERN];
    logic [BYTE_W-1:0]      pat_reg  [MAX_PATTERN];
    logic [BYTE_W-1:0]      pat_next [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] wild_reg;
    logic [MAX_PATTERN-1:0] wild_next;

    logic [CFG_LEN_W-1:0]   len_cfg_reg;
    logic [CFG_LEN_W-1:0]   len_cfg_next;
    logic [ADDR_W-1:0]      start_reg;
    logic [ADDR_W-1:0]      start_next;
    logic [CNT_W-1:0]       seen_reg;
    logic [CNT_W-1:0]       seen_next;
    logic [ADDR_W-1:0]      offs_reg;
    logic [ADDR_W-1:0]      offs_next;

    logic                   a_valid_reg;
    logic                   a_valid_next;
    logic [REQ_W-1:0]       a_kind_reg;
    logic [REQ_W-1:0]       a_kind_next;
    logic                   a_last_reg;
    logic                   a_last_next;
    logic [MAX_PATTERN-1:0] a_hit_reg;
    logic [MAX_PATTERN-1:0] a_hit_next;
    logic                   a_enough_reg;
    logic                   a_enough_next;
    logic [ADDR_W-1:0]      a_cur_reg;
    logic [ADDR_W-1:0]      a_cur_next;

    logic                   done_reg;
    logic                   done_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   found_reg;
    logic                   found_next;
    logic [ADDR_W-1:0]      addr_reg;
    logic [ADDR_W-1:0]      addr_next;

    logic [CNT_W-1:0]       len_eff;
    logic [PIDX_W-1:0]      lm1;
    logic [CNT_W-1:0]       seen_inc;
    logic                   adv;
    logic                   take;
    logic                   b_fire;
    logic                   b_match;
    logic                   cfg_len_wr;
    logic [CNT_W-1:0]       new_len;
    logic [CNT_W-1:0]       shamt;
    logic [BYTE_W*MAX_PATTERN-1:0] rev_flat;
    logic [BYTE_W*MAX_PATTERN-1:0] rot_flat;

    assign len_eff    = eff_len(len_cfg_reg);
    assign lm1        = PIDX_W'(len_eff - 1'b1);
    assign adv        = !out_valid_reg || out_ready;
    assign take       = adv && q_valid;
    assign q_pop      = take;
    assign b_fire     = adv && a_valid_reg;
    assign b_match    = (&a_hit_reg) && a_enough_reg;
    assign cfg_len_wr = cfg_valid && (cfg_index == CFG_LENGTH);
    assign new_len    = eff_len(cfg_data[CFG_LEN_W-1:0]);
    assign shamt      = CNT_W'(MAX_PATTERN) - new_len;
    assign seen_inc   = (seen_reg == CNT_W'(MAX_PATTERN)) ? seen_reg : seen_reg + 1'b1;

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign match_address = addr_reg;

    // aligned copy: entry i holds the byte that pattern position i is compared with
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN - 1; i++)
        begin
            aln_shift[i] = (PIDX_W'(i) == lm1) ? q_cmd.value : aln_reg[i + 1];
        end
        aln_shift[MAX_PATTERN-1] = (PIDX_W'(MAX_PATTERN - 1) == lm1) ? q_cmd.value
                                                                   : aln_reg[MAX_PATTERN-1];
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            rev_flat[BYTE_W*j +: BYTE_W] = win_reg[MAX_PATTERN-1-j];
        end
        rot_flat = rev_flat >> {shamt, 3'b000};
    end

    always_comb
    begin
        win_next     = win_reg;
        aln_next     = aln_reg;
        pat_next     = pat_reg;
        wild_next    = wild_reg;
        len_cfg_next = len_cfg_reg;
        start_next   = start_reg;
        seen_next    = seen_reg;
        offs_next    = offs_reg;

        a_valid_next  = a_valid_reg;
        a_kind_next   = a_kind_reg;
        a_last_next   = a_last_reg;
        a_hit_next    = a_hit_reg;
        a_enough_next = a_enough_reg;
        a_cur_next    = a_cur_reg;

        if (adv)
        begin
            a_valid_next  = take && (q_cmd.kind != REQ_LOAD);
            a_kind_next   = q_cmd.kind;
            a_last_next   = q_cmd.last;
            a_enough_next = (seen_inc >= len_eff);
            a_cur_next    = start_reg + offs_reg;
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                a_hit_next[i] = (CNT_W'(i) >= len_eff) || wild_reg[i] ||
                                (aln_shift[i] == pat_reg[i]);
            end
        end

        if (take)
        begin
            case (q_cmd.kind)
                REQ_LOAD:
                begin
                    for (int i = 0; i < MAX_PATTERN; i++)
                    begin
                        if (q_cmd.index == ENTRY_IDX_W'(i))
                        begin
                            pat_next[i]  = q_cmd.value;
                            wild_next[i] = q_cmd.wild;
                        end
                    end
                end
                REQ_SCAN:
                begin
                    for (int i = MAX_PATTERN - 1; i > 0; i--)
                    begin
                        win_next[i] = win_reg[i - 1];
                    end
                    win_next[0] = q_cmd.value;
                    aln_next    = aln_shift;
                    seen_next   = seen_inc;
                    offs_next   = offs_reg + 1'b1;
                end
                REQ_RESTART:
                begin
                    seen_next = '0;
                    offs_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LENGTH: len_cfg_next = cfg_data[CFG_LEN_W-1:0];
                CFG_START:  start_next   = cfg_data[ADDR_W-1:0];
                default:
                begin
                end
            endcase
        end

        // realign the compare window to the new length
        if (cfg_len_wr)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                aln_next[i] = rot_flat[BYTE_W*i +: BYTE_W];
            end
        end
    end

    always_comb
    begin
        done_next      = done_reg;
        out_valid_next = adv ? 1'b0 : out_valid_reg;
        found_next     = found_reg;
        addr_next      = addr_reg;
        if (b_fire)
        begin
            case (a_kind_reg)
                REQ_RESTART:
                begin
                    done_next = 1'b0;
                end
                REQ_SCAN:
                begin
                    if (!done_reg)
                    begin
                        if (b_match)
                        begin
                            done_next      = 1'b1;
                            out_valid_next = 1'b1;
                            found_next     = 1'b1;
                            addr_next      = a_cur_reg - ADDR_W'(lm1);
                        end
                        else if (a_last_reg)
                        begin
                            done_next      = 1'b1;
                            out_valid_next = 1'b1;
                            found_next     = 1'b0;
                            addr_next      = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg   <= CFG_LEN_W'(1);
            start_reg     <= '0;
            seen_reg      <= '0;
            offs_reg      <= '0;
            a_valid_reg   <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_cfg_reg   <= len_cfg_next;
            start_reg     <= start_next;
            seen_reg      <= seen_next;
            offs_reg      <= offs_next;
            a_valid_reg   <= a_valid_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg      <= win_next;
        aln_reg      <= aln_next;
        pat_reg      <= pat_next;
        wild_reg     <= wild_next;
        a_kind_reg   <= a_kind_next;
        a_last_reg   <= a_last_next;
        a_hit_reg    <= a_hit_next;
        a_enough_reg <= a_enough_next;
        a_cur_reg    <= a_cur_next;
        found_reg    <= found_next;
        addr_reg     <= addr_next;
    end

endmodule

### rtl/core/wildcard_byte_pattern_scan_top.sv
// Wildcard byte pattern scanner. Load pattern positions with load requests (every
// position below pattern_length must be written before scanning), then stream one
// memory byte per scan request; the first place where all positions match (wild
// positions match any byte) is reported once with found=1 and the address of its
// first byte, or found=0 with address 0 when the byte flagged last_byte passes
// unmatched. Further scan requests are dropped until a restart request. One request
// is accepted per clock while in_ready is high; the compare of all 64 positions runs
// in one stage against a length-aligned copy of the byte window, between the queue
// and the output register. Requests keep flowing while a result waits, until the
// two-entry request queue and the input stage fill. Write pattern_length and
// start_address only while no request is in flight; the config port is always ready.
`include "assert_macros.svh"

module wildcard_byte_pattern_scan_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [wbps_pkg::REQ_W-1:0]       req_type,
    input  logic [wbps_pkg::ENTRY_IDX_W-1:0] entry_index,
    input  logic [wbps_pkg::BYTE_W-1:0]      entry_value,
    input  logic                             entry_wild,
    input  logic [wbps_pkg::BYTE_W-1:0]      data_byte,
    input  logic                             last_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             found,
    output logic [wbps_pkg::ADDR_W-1:0]      match_address
);
    import wbps_pkg::*;

    logic f_valid;
    logic q_ready;
    cmd_t f_cmd;
    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    assign cfg_ready = 1'b1;

    wbps_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .entry_wild  (entry_wild),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .push_valid  (f_valid),
        .push_ready  (q_ready),
        .push_cmd    (f_cmd)
    );

    wbps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (q_ready),
        .push_cmd   (f_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    wbps_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .match_address (match_address)
    );

    `WBPS_IMP(a_nf_addr_zero, out_valid && !found, match_address == '0)
    `WBPS_IMP(a_pop_nonempty, q_pop, q_valid)
    `WBPS_NXT(a_front_holds, f_valid && !q_ready, f_valid)

endmodule

### tb/wbps_checker.sv
module wbps_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [wbps_pkg::REQ_W-1:0]       req_type,
    input  logic [wbps_pkg::ENTRY_IDX_W-1:0] entry_index,
    input  logic [wbps_pkg::BYTE_W-1:0]      entry_value,
    input  logic                             entry_wild,
    input  logic [wbps_pkg::BYTE_W-1:0]      data_byte,
    input  logic                             last_byte,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic                             found,
    input  logic [wbps_pkg::ADDR_W-1:0]      match_address,
    output int                               bad_reports,
    output int                               reports_open
);
    timeunit 1ns;
    timeprecision 1ps;
    import wbps_pkg::*;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] addr;
    } scan_report_t;

    scan_report_t      reports_due [$];
    logic [BYTE_W-1:0] sig_byte [MAX_PATTERN];
    logic              sig_wild [MAX_PATTERN];
    logic [BYTE_W-1:0] recent [MAX_PATTERN];
    int                bytes_taken;
    logic [ADDR_W-1:0] offset;
    logic              finished;
    logic [CFG_LEN_W-1:0] len_reg;
    logic [ADDR_W-1:0] base_reg;
    int                reports_seen;

    task automatic clear_window();
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            recent[i] = '0;
        end
        bytes_taken = 0;
        offset = '0;
        finished = 1'b0;
    endtask

    task automatic take_scan_byte(input logic [BYTE_W-1:0] b, input logic fin);
        int len;
        logic hit;
        logic [ADDR_W-1:0] here;
        logic [ADDR_W-1:0] back;
        scan_report_t r;
        if (finished)
        begin
            return;
        end
        for (int i = MAX_PATTERN - 1; i > 0; i--)
        begin
            recent[i] = recent[i-1];
        end
        recent[0] = b;
        if (bytes_taken < MAX_PATTERN)
        begin
            bytes_taken++;
        end
        here = base_reg + offset;
        offset = offset + 1'b1;
        if (len_reg == '0)
        begin
            len = 1;
        end
        else if (int'(len_reg) > MAX_PATTERN)
        begin
            len = MAX_PATTERN;
        end
        else
        begin
            len = int'(len_reg);
        end
        hit = (bytes_taken >= len);
        for (int i = 0; i < len; i++)
        begin
            if (hit && !sig_wild[i] && recent[len-1-i] != sig_byte[i])
            begin
                hit = 1'b0;
            end
        end
        if (hit)
        begin
            back = ADDR_W'(len - 1);
            finished = 1'b1;
            r.hit = 1'b1;
            r.addr = here - back;
            reports_due.push_back(r);
        end
        else if (fin)
        begin
            finished = 1'b1;
            r = '0;
            reports_due.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_window();
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                sig_byte[i] = '0;
                sig_wild[i] = 1'b0;
            end
            len_reg = CFG_LEN_W'(1);
            base_reg = '0;
            reports_due.delete();
            reports_open = 0;
            bad_reports = 0;
            reports_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LENGTH: len_reg = cfg_data[CFG_LEN_W-1:0];
                    CFG_START:  base_reg = cfg_data[ADDR_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                reports_seen++;
                if (reports_due.size() == 0)
                begin
                    if (bad_reports < 10)
                    begin
                        $display("report %0d: nothing pending, got found=%0b addr=%h",
                                 reports_seen, found, match_address);
                    end
                    bad_reports++;
                end
                else
                begin
                    scan_report_t e;
                    e = reports_due.pop_front();
                    if (found !== e.hit || match_address !== e.addr)
                    begin
                        if (bad_reports < 10)
                        begin
                            $display("report %0d: exp found=%0b addr=%h got found=%0b addr=%h",
                                     reports_seen, e.hit, e.addr, found, match_address);
                        end
                        bad_reports++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                case (req_type)
                    REQ_LOAD:
                    begin
                        sig_byte[entry_index] = entry_value;
                        sig_wild[entry_index] = entry_wild;
                    end
                    REQ_SCAN:    take_scan_byte(data_byte, last_byte);
                    REQ_RESTART: clear_window();
                    default: ;
                endcase
            end
            reports_open = reports_due.size();
        end
    end

endmodule

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wbps_pkg::*;

    localparam logic [REQ_W-1:0] REQ_BOGUS = 2'd3;
    localparam int STIM_TARGET = 2000;
    localparam int DRAIN = 10;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [REQ_W-1:0]       req_type = '0;
    logic [ENTRY_IDX_W-1:0] entry_index = '0;
    logic [BYTE_W-1:0]      entry_value = '0;
    logic                   entry_wild = 1'b0;
    logic [BYTE_W-1:0]      data_byte = '0;
    logic                   last_byte = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   found;
    logic [ADDR_W-1:0]      match_address;
    int                     bad_reports;
    int                     reports_open;

    int send_idle = 30;
    int recv_idle = 62;
    int stim_count = 0;
    logic [CFG_LEN_W-1:0] len_now = CFG_LEN_W'(1);
    logic [BYTE_W-1:0]    sig_copy [MAX_PATTERN];
    logic                 sig_copy_wild [MAX_PATTERN];
    logic                 loaded [MAX_PATTERN];

    wildcard_byte_pattern_scan_top uut (.*);

    wbps_checker u_checker (.*);

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("wildcard_byte_pattern_scan_top: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic int span();
        if (len_now == '0)
        begin
            return 1;
        end
        if (int'(len_now) > MAX_PATTERN)
        begin
            return MAX_PATTERN;
        end
        return int'(len_now);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return '1 - ADDR_W'($urandom_range(70));
            default: return r[ADDR_W-1:0];
        endcase
    endfunction

    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [ENTRY_IDX_W-1:0] idx,
                            input logic [BYTE_W-1:0] val, input logic wild,
                            input logic [BYTE_W-1:0] b, input logic fin, input bit tally);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        entry_index <= idx;
        entry_value <= val;
        entry_wild <= wild;
        data_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if (kind == REQ_LOAD)
        begin
            sig_copy[idx] = val;
            sig_copy_wild[idx] = wild;
            loaded[idx] = 1'b1;
        end
        if (tally)
        begin
            stim_count++;
        end
    endtask

    task automatic load_entry(input int idx, input logic [BYTE_W-1:0] val, input logic wild);
        send_req(REQ_LOAD, ENTRY_IDX_W'(idx), val, wild, BYTE_W'($urandom),
                 1'($urandom), 1'b1);
    endtask

    task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic fin);
        send_req(REQ_SCAN, ENTRY_IDX_W'($urandom), BYTE_W'($urandom), 1'($urandom),
                 b, fin, 1'b1);
    endtask

    task automatic restart_scan();
        send_req(REQ_RESTART, ENTRY_IDX_W'($urandom), BYTE_W'($urandom), 1'($urandom),
                 BYTE_W'($urandom), 1'($urandom), 1'b1);
    endtask

    task automatic odd_req();
        send_req(REQ_BOGUS, ENTRY_IDX_W'($urandom), BYTE_W'($urandom), 1'($urandom),
                 BYTE_W'($urandom), 1'($urandom), 1'b0);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (reports_open != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_LENGTH)
        begin
            len_now = val[CFG_LEN_W-1:0];
        end
    endtask

    task automatic fill_pattern();
        for (int i = 0; i < span(); i++)
        begin
            if (!loaded[i])
            begin
                load_entry(i, BYTE_W'($urandom), $urandom_range(99) < 25);
            end
        end
    endtask

    task automatic pick_config();
        logic [CFG_DATA_W-1:0] v;
        logic [63:0] noise;
        int sel;
        sel = $urandom_range(99);
        noise = {$urandom, $urandom};
        if (sel < 60)
        begin
            v = CFG_DATA_W'($urandom_range(1, 8));
        end
        else if (sel < 80)
        begin
            v = CFG_DATA_W'($urandom_range(9, 64));
        end
        else if (sel < 86)
        begin
            v = '0;
        end
        else if (sel < 92)
        begin
            v = CFG_DATA_W'(MAX_PATTERN);
        end
        else
        begin
            v = CFG_DATA_W'($urandom_range(65, 127));
        end
        if ($urandom_range(3) == 0)
        begin
            v = {noise[CFG_DATA_W-1:CFG_LEN_W], v[CFG_LEN_W-1:0]};
        end
        write_reg(CFG_LENGTH, v);
        if ($urandom_range(1) == 1)
        begin
            write_reg(CFG_START, pick_addr());
        end
    endtask

    task automatic scan_session();
        int w;
        int total;
        int pos;
        int pick;
        int flip;
        int stop;
        bit moved;
        bit aborted;
        logic [BYTE_W-1:0] stream [];
        settle();
        pick_config();
        fill_pattern();
        repeat ($urandom_range(3))
        begin
            load_entry($urandom_range(MAX_PATTERN - 1), BYTE_W'($urandom),
                       $urandom_range(99) < 25);
        end
        restart_scan();
        w = span();
        total = w + $urandom_range(w + 12);
        stream = new[total];
        for (int k = 0; k < total; k++)
        begin
            stream[k] = ($urandom_range(1) == 1) ? sig_copy[$urandom_range(w - 1)]
                                                 : BYTE_W'($urandom);
        end
        pick = $urandom_range(9);
        if (pick < 8)
        begin
            pos = $urandom_range(total - w);
            for (int j = 0; j < w; j++)
            begin
                if (!sig_copy_wild[j])
                begin
                    stream[pos + j] = sig_copy[j];
                end
            end
            if (pick >= 6)
            begin
                flip = $urandom_range(w - 1);
                stream[pos + flip] = stream[pos + flip] ^ BYTE_W'(1 << $urandom_range(7));
            end
        end
        aborted = ($urandom_range(9) == 0);
        stop = ($urandom_range(19) == 0) ? $urandom_range(total - 1) : total - 1;
        moved = 1'b0;
        for (int k = 0; k < total; k++)
        begin
            if ($urandom_range(99) < 4)
            begin
                odd_req();
            end
            if ($urandom_range(99) < 4)
            begin
                load_entry($urandom_range(MAX_PATTERN - 1), BYTE_W'($urandom),
                           $urandom_range(99) < 25);
            end
            if (!moved && $urandom_range(99) < 3)
            begin
                moved = 1'b1;
                settle();
                pick_config();
                fill_pattern();
            end
            scan_byte(stream[k], !aborted && k == stop);
        end
        if (aborted)
        begin
            restart_scan();
        end
        else
        begin
            repeat ($urandom_range(2))
            begin
                send_req(REQ_SCAN, ENTRY_IDX_W'($urandom), BYTE_W'($urandom), 1'($urandom),
                         BYTE_W'($urandom), 1'($urandom), 1'b0);
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            loaded[i] = 1'b0;
            sig_copy[i] = '0;
            sig_copy_wild[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_LENGTH, CFG_DATA_W'(3));
        write_reg(CFG_START, 48'hFFFF_FFFF_FFFE);
        load_entry(0, 8'h00, 1'b0);
        load_entry(1, 8'hAA, 1'b1);
        load_entry(2, 8'hFF, 1'b0);
        load_entry(63, 8'h5A, 1'b1);
        restart_scan();
        scan_byte(8'h00, 1'b0);
        scan_byte(8'h13, 1'b0);
        scan_byte(8'hFF, 1'b0);
        scan_byte(8'h00, 1'b1);
        odd_req();
        restart_scan();
        scan_byte(8'h00, 1'b0);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'h77, 1'b0);
        scan_byte(8'hFF, 1'b1);
        restart_scan();
        scan_byte(8'h00, 1'b0);
        load_entry(2, 8'h11, 1'b0);
        scan_byte(8'h55, 1'b0);
        scan_byte(8'h11, 1'b0);
        restart_scan();
        scan_byte(8'h01, 1'b1);

        while (stim_count < STIM_TARGET)
        begin
            if (stim_count >= 2 * STIM_TARGET / 3)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            else if (stim_count >= STIM_TARGET / 3)
            begin
                send_idle = 62;
                recv_idle = 30;
            end
            scan_session();
        end
        settle();

        if (bad_reports == 0 && reports_open == 0)
        begin
            $display("wildcard_byte_pattern_scan_top: match");
        end
        else
        begin
            $display("wildcard_byte_pattern_scan_top: mismatch");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/wbps_pkg.sv
rtl/core/wbps_front.sv
rtl/core/wbps_queue.sv
rtl/core/wbps_back.sv
rtl/core/wildcard_byte_pattern_scan_top.sv
tb/wbps_checker.sv
tb/tb_top.sv
